FILE: sv/laplacian_variance_focus_unit_assert.svh
// Assertion macros for the focus measure RTL.
`ifndef LAPLACIAN_VARIANCE_FOCUS_UNIT_ASSERT_SVH
`define LAPLACIAN_VARIANCE_FOCUS_UNIT_ASSERT_SVH

// Condition must hold whenever the antecedent holds, in the same cycle.
`define LVF_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define LVF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/lvf_pkg.sv
// Types, widths and codes shared by the focus measure blocks.
`timescale 1ns / 1ps
package lvf_pkg;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 13;
  localparam int SUM_W   = 35;
  localparam int SQ_W    = 44;
  localparam int Q_W     = 28;
  localparam int CNT_W   = 24;
  localparam int LAP_W   = 11;
  localparam int N_W     = 26;
  localparam int ACC_W   = 70;
  localparam int NUM_W   = 80;
  localparam int CFG_IDX_W = 4;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  // Per-frame statistics handed from the pixel front end to the back end.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sumsq;
    logic [DIM_W-1:0] wm2;
    logic [DIM_W-1:0] hm2;
    logic             no_interior;
  } lvf_frame_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic room;
  } lvf_fifo_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUB,
    BK_DIV,
    BK_OUT
  } lvf_back_state_t;

endpackage

FILE: sv/lvf_if.sv
// Channel interfaces: pixel words in, configuration writes in, result words out.
`timescale 1ns / 1ps
interface lvf_pix_if;
  import lvf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             start_of_frame;
  modport source(output valid, pixel, start_of_frame, input ready);
  modport sink(input valid, pixel, start_of_frame, output ready);
endinterface

interface lvf_cfg_if;
  import lvf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface lvf_res_if;
  import lvf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [Q_W-1:0]          variance_q8;
  logic signed [SUM_W-1:0] laplacian_sum;
  logic [SQ_W-1:0]         laplacian_sum_squares;
  logic [CNT_W-1:0]        interior_count;
  modport source(output valid, variance_q8, laplacian_sum, laplacian_sum_squares,
                 interior_count, input ready);
  modport sink(input valid, variance_q8, laplacian_sum, laplacian_sum_squares,
               interior_count, output ready);
endinterface

FILE: sv/laplacian_variance_focus_unit.sv
// Variance-of-Laplacian focus measure, top level.
// Pixels are taken one word per cycle in raster order when the input is not
// stalled; frame width and height come from two configuration registers. The
// front end reads both line buffers (one read and one write port each, read
// data registered) and accumulates exact Laplacian sums in a pipeline. At the
// last pixel of a frame the totals go into a four-entry queue. The back end
// turns one queued frame into a result by taking it from the queue, eight
// steps on a shared 26x26 multiplier, one compare and subtract, 28 steps of a
// restoring divider and loading the result register; the divider is skipped
// when the numerator is negative or the quotient saturates. Input stalls only
// when more than one frame is waiting in the queue. Frames narrower or shorter
// than three give an all-zero result. Line buffer contents are undefined after
// reset; no clearing pass is run.
`timescale 1ns / 1ps
module laplacian_variance_focus_unit #(
  parameter int MAX_WIDTH  = lvf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lvf_pkg::DEF_MAX_HEIGHT
) (
  input logic       clk,
  input logic       rst,
  lvf_pix_if.sink   pixels,
  lvf_cfg_if.sink   cfg,
  lvf_res_if.source results
);
  import lvf_pkg::*;
  `include "laplacian_variance_focus_unit_assert.svh"

  logic           fifo_push, fifo_pop;
  lvf_frame_t     push_frame, head_frame;
  lvf_fifo_stat_t fifo_stat;

  lvf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels),
    .cfg      (cfg),
    .fifo_stat(fifo_stat),
    .push     (fifo_push),
    .frame    (push_frame)
  );

  lvf_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (fifo_push),
    .wdata(push_frame),
    .pop  (fifo_pop),
    .rdata(head_frame),
    .stat (fifo_stat)
  );

  lvf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .fifo_stat(fifo_stat),
    .head     (head_frame),
    .pop      (fifo_pop),
    .results  (results)
  );

  // Queue never overflows or underflows.
  `LVF_ASSERT_IMP(a_no_overflow, fifo_push, !fifo_stat.full, "frame queue overflow")
  `LVF_ASSERT_IMP(a_no_underflow, fifo_pop, !fifo_stat.empty, "frame queue underflow")
  // An empty interior means an all-zero result word.
  `LVF_ASSERT_IMP(a_small_zero, results.valid && results.interior_count == '0, results.laplacian_sum == '0 && results.variance_q8 == '0, "nonzero stats with no interior")
  // A pop starts work, so the back end cannot pop twice in a row.
  `LVF_ASSERT_NEXT(a_single_pop, fifo_pop, !fifo_pop, "back end popped twice in a row")

endmodule

FILE: sv/lvf_front.sv
// Pixel front end: config registers, line buffers, 3x3 window, Laplacian sums.
`timescale 1ns / 1ps
module lvf_front #(
  parameter int MAX_WIDTH  = lvf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lvf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  lvf_pix_if.sink                pixels,
  lvf_cfg_if.sink                cfg,
  input  lvf_pkg::lvf_fifo_stat_t fifo_stat,
  output logic                   push,
  output lvf_pkg::lvf_frame_t    frame
);
  import lvf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [DIM_W-1:0] frame_width, frame_height;
  logic [CW-1:0]    wm1;
  logic [RW-1:0]    hm1;
  logic             no_interior;
  logic [CW-1:0]    column_count, column_count_next, col_eff;
  logic [RW-1:0]    row_count, row_count_next, row_eff;
  logic             accept, col_end, last;

  logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] up_q, mid_q;

  logic             s1_valid, s1_lap_en, s1_last, s1_clear, s1_small;
  logic [PIX_W-1:0] s1_px;
  logic [CW-1:0]    s1_idx;
  logic [DIM_W-1:0] s1_wm2, s1_hm2;
  logic [PIX_W-1:0] window_regs [6];
  logic signed [LAP_W-1:0] lap;

  logic             s2_valid, s2_lap_en, s2_last, s2_clear, s2_small;
  logic signed [LAP_W-1:0] s2_lap;
  logic [DIM_W-1:0] s2_wm2, s2_hm2;
  logic signed [2*LAP_W-1:0] sq_full;
  logic [SUM_W-1:0] running_sum, sum_next;
  logic [SQ_W-1:0]  running_sum_squares, sumsq_next;

  // Configuration writes; the port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Last column and row index; zero acts as one, large values saturate.
  always_comb begin
    priority if (frame_width == '0) wm1 = '0;
    else if (32'(frame_width) > MAX_WIDTH) wm1 = CW'(MAX_WIDTH - 1);
    else wm1 = CW'(frame_width - 1'b1);
    priority if (frame_height == '0) hm1 = '0;
    else if (32'(frame_height) > MAX_HEIGHT) hm1 = RW'(MAX_HEIGHT - 1);
    else hm1 = RW'(frame_height - 1'b1);
  end

  assign no_interior = (wm1 < CW'(2)) || (hm1 < RW'(2));

  // Raster position; a start-of-frame word restarts at the origin.
  assign pixels.ready = fifo_stat.room;
  assign accept  = pixels.valid && pixels.ready;
  assign col_eff = pixels.start_of_frame ? '0 : column_count;
  assign row_eff = pixels.start_of_frame ? '0 : row_count;
  assign col_end = col_eff >= wm1;
  assign last    = col_end && (row_eff >= hm1);

  always_comb begin
    column_count_next = col_eff + 1'b1;
    row_count_next    = row_eff;
    if (col_end) begin
      column_count_next = '0;
      row_count_next    = last ? '0 : row_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Line buffers: read on accept, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_q  <= upper_line[col_eff];
      mid_q <= middle_line[col_eff];
    end
    if (s1_valid) begin
      upper_line[s1_idx]  <= mid_q;
      middle_line[s1_idx] <= s1_px;
    end
  end

  // First stage: word classification.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_px     <= pixels.pixel;
    s1_idx    <= col_eff;
    s1_lap_en <= (row_eff >= RW'(2)) && (col_eff >= CW'(2));
    s1_last   <= last;
    s1_clear  <= pixels.start_of_frame;
    s1_small  <= no_interior;
    s1_wm2    <= DIM_W'(wm1) - DIM_W'(1);
    s1_hm2    <= DIM_W'(hm1) - DIM_W'(1);
  end

  // Four-neighbour Laplacian from the window before its shift.
  assign lap = (LAP_W'(window_regs[2]) <<< 2) - LAP_W'(window_regs[4])
             - LAP_W'(window_regs[5]) - LAP_W'(window_regs[1]) - LAP_W'(mid_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) window_regs[i] <= '0;
    end else if (s1_valid) begin
      window_regs[0] <= window_regs[1];
      window_regs[1] <= window_regs[2];
      window_regs[2] <= mid_q;
      window_regs[3] <= window_regs[4];
      window_regs[4] <= up_q;
      window_regs[5] <= s1_px;
    end
  end

  // Second stage: square and accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_lap    <= lap;
    s2_lap_en <= s1_lap_en;
    s2_last   <= s1_last;
    s2_clear  <= s1_clear;
    s2_small  <= s1_small;
    s2_wm2    <= s1_wm2;
    s2_hm2    <= s1_hm2;
  end

  assign sq_full = s2_lap * s2_lap;

  always_comb begin
    sum_next   = s2_clear ? '0 : running_sum;
    sumsq_next = s2_clear ? '0 : running_sum_squares;
    if (s2_lap_en) begin
      sum_next   = sum_next + SUM_W'(s2_lap);
      sumsq_next = sumsq_next + SQ_W'(unsigned'(sq_full));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum         <= '0;
      running_sum_squares <= '0;
    end else if (s2_valid) begin
      running_sum         <= s2_last ? '0 : sum_next;
      running_sum_squares <= s2_last ? '0 : sumsq_next;
    end
  end

  // End of frame: hand the totals to the queue.
  assign push              = s2_valid && s2_last;
  assign frame.sum         = sum_next;
  assign frame.sumsq       = sumsq_next;
  assign frame.wm2         = s2_wm2;
  assign frame.hm2         = s2_hm2;
  assign frame.no_interior = s2_small;

endmodule

FILE: sv/lvf_fifo.sv
// Short queue of per-frame totals between the front end and the back end.
`timescale 1ns / 1ps
module lvf_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  lvf_pkg::lvf_frame_t     wdata,
  input  logic                    pop,
  output lvf_pkg::lvf_frame_t     rdata,
  output lvf_pkg::lvf_fifo_stat_t stat
);
  import lvf_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  lvf_frame_t    entries [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  assign rdata      = entries[rd_ptr];
  assign stat.full  = count == (PW+1)'(FIFO_DEPTH);
  assign stat.empty = count == '0;
  // Two frames may still be in the front pipeline plus the word now offered.
  assign stat.room  = count <= (PW+1)'(FIFO_DEPTH - 3);

endmodule

FILE: sv/lvf_back.sv
// Back end: shared multiplier, exact variance numerator, serial divider, result register.
`timescale 1ns / 1ps
module lvf_back (
  input  logic                clk,
  input  logic                rst,
  input  lvf_pkg::lvf_fifo_stat_t fifo_stat,
  input  lvf_pkg::lvf_frame_t head,
  output logic                pop,
  lvf_res_if.source           results
);
  import lvf_pkg::*;

  localparam logic [Q_W-1:0] QMAX = '1;

  lvf_back_state_t state, state_next;
  lvf_frame_t      cur;
  logic [2:0]      step;
  logic [4:0]      div_cnt;
  logic [N_W-1:0]  op_a, op_b, n;
  logic [2*N_W-1:0] prod, d;
  logic [ACC_W-1:0] acc_a, acc_b;
  logic [SUM_W-1:0] mag;
  logic [NUM_W-1:0] num, rem, dsh;
  logic             lt, sat, load;
  logic [Q_W-1:0]   q;
  logic             out_valid;

  assign mag = cur.sum[SUM_W-1] ? -cur.sum : cur.sum;

  // Multiplier operands for each sequencer step.
  always_comb begin
    unique case (step)
      3'd0: begin op_a = N_W'(cur.wm2);    op_b = N_W'(cur.hm2);          end
      3'd1: begin op_a = N_W'(mag[34:17]); op_b = N_W'(mag[34:17]);       end
      3'd2: begin op_a = N_W'(mag[34:17]); op_b = N_W'(mag[16:0]);        end
      3'd3: begin op_a = N_W'(mag[16:0]);  op_b = N_W'(mag[16:0]);        end
      3'd4: begin op_a = n;                op_b = N_W'(cur.sumsq[21:0]);  end
      3'd5: begin op_a = n;                op_b = N_W'(cur.sumsq[43:22]); end
      3'd6: begin op_a = n;                op_b = n;                      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign num = NUM_W'({acc_a - acc_b, 8'b0});
  assign lt  = acc_a < acc_b;
  assign sat = num >= (NUM_W'(d) << Q_W);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!fifo_stat.empty) state_next = head.no_interior ? BK_OUT : BK_MUL;
      BK_MUL:  if (step == 3'd7) state_next = BK_SUB;
      BK_SUB:  state_next = (lt || sat) ? BK_OUT : BK_DIV;
      BK_DIV:  if (div_cnt == '0) state_next = BK_OUT;
      BK_OUT:  if (!out_valid || results.ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop  = (state == BK_IDLE) && !fifo_stat.empty;
    load = (state == BK_OUT) && (!out_valid || results.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Datapath: product steps, numerator, restoring division.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head;
      step <= '0;
      q    <= '0;
    end
    if (state == BK_MUL) begin
      prod <= op_a * op_b;
      step <= step + 1'b1;
      unique case (step)
        3'd1: n     <= prod[N_W-1:0];
        3'd2: acc_b <= ACC_W'(prod) << 34;
        3'd3: acc_b <= acc_b + (ACC_W'(prod) << 18);
        3'd4: acc_b <= acc_b + ACC_W'(prod);
        3'd5: acc_a <= ACC_W'(prod);
        3'd6: acc_a <= acc_a + (ACC_W'(prod) << 22);
        3'd7: d     <= prod;
        default: ;
      endcase
    end
    if (state == BK_SUB) begin
      rem     <= num;
      dsh     <= NUM_W'(d) << (Q_W - 1);
      div_cnt <= 5'(Q_W - 1);
      priority if (lt) q <= '0;
      else if (sat)    q <= QMAX;
    end
    if (state == BK_DIV) begin
      div_cnt <= div_cnt - 1'b1;
      dsh     <= dsh >> 1;
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[Q_W-2:0], 1'b1};
      end else begin
        q   <= {q[Q_W-2:0], 1'b0};
      end
    end
  end

  // Result register decouples the divider from the output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      results.variance_q8           <= cur.no_interior ? '0 : q;
      results.laplacian_sum         <= cur.no_interior ? '0 : cur.sum;
      results.laplacian_sum_squares <= cur.no_interior ? '0 : cur.sumsq;
      results.interior_count        <= cur.no_interior ? '0 : n[CNT_W-1:0];
    end
  end

  assign results.valid = out_valid;

endmodule

FILE: test/laplacian_variance_focus_unit_tb.sv
// Self-checking testbench for the Laplacian variance focus unit.
`timescale 1ns / 1ps
module laplacian_variance_focus_unit_tb;
  import lvf_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXH = DEF_MAX_HEIGHT;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [Q_W-1:0]          var_q8;
    logic signed [SUM_W-1:0] lap_sum;
    logic [SQ_W-1:0]         lap_sq;
    logic [CNT_W-1:0]        count;
  } focus_stats_t;

  // Tracks the frame statistics the unit should report and checks them.
  class focus_scoreboard;
    logic [DIM_W-1:0]        width_reg, height_reg;
    logic [PIX_W-1:0]        row_above2 [MAXW];
    logic [PIX_W-1:0]        row_above1 [MAXW];
    logic [PIX_W-1:0]        win [6];
    int                      col, row;
    logic signed [SUM_W-1:0] acc_sum;
    logic [SQ_W-1:0]         acc_sq;
    focus_stats_t            pending_stats [$];
    int                      mismatches, frames_checked;

    function void clear_state();
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      foreach (win[i]) win[i] = '0;
      foreach (row_above1[i]) begin
        row_above1[i] = '0;
        row_above2[i] = '0;
      end
      col = 0;
      row = 0;
      acc_sum = '0;
      acc_sq = '0;
      mismatches = 0;
      frames_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) width_reg = value;
      else if (idx == REG_FRAME_HEIGHT) height_reg = value;
    endfunction

    function int clamp(logic [DIM_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return int'(v);
    endfunction

    // Exact Q8 variance: floor(256*(n*sq - sum^2)/n^2), saturated to 28 bits.
    function logic [Q_W-1:0] variance_of(logic [25:0] n);
      logic [79:0] a, b, mag, num, quo;
      a = 80'(n) * 80'(acc_sq);
      mag = acc_sum < 0 ? 80'(-acc_sum) : 80'(acc_sum);
      b = mag * mag;
      if (a < b) return '0;
      num = (a - b) << 8;
      quo = num / (80'(n) * 80'(n));
      if (quo > 80'h0FFFFFFF) return '1;
      return quo[Q_W-1:0];
    endfunction

    // Takes one accepted pixel word; queues a result on the last pixel of a frame.
    function void note_pixel(logic [PIX_W-1:0] px, logic sof);
      int w, h, idx, lap;
      logic [PIX_W-1:0] up2, up1;
      logic [25:0] n;
      focus_stats_t st;
      logic last;
      w = clamp(width_reg, MAXW);
      h = clamp(height_reg, MAXH);
      if (sof) begin
        col = 0;
        row = 0;
        acc_sum = '0;
        acc_sq = '0;
      end
      idx = col < MAXW ? col : MAXW - 1;
      up2 = row_above2[idx];
      up1 = row_above1[idx];
      win[0] = win[1];
      win[1] = win[2];
      win[2] = up1;
      win[3] = win[4];
      win[4] = up2;
      if (row >= 2 && col >= 2) begin
        lap = 4 * int'(win[1]) - int'(win[3]) - int'(win[5]) - int'(win[0]) - int'(win[2]);
        acc_sum = acc_sum + SUM_W'(lap);
        acc_sq = acc_sq + SQ_W'(lap * lap);
      end
      win[5] = px;
      row_above2[idx] = up1;
      row_above1[idx] = px;
      last = col >= w - 1 && row >= h - 1;
      if (col >= w - 1) begin
        col = 0;
        row = row >= h - 1 ? 0 : row + 1;
      end else begin
        col++;
      end
      if (!last) return;
      if (w < 3 || h < 3) begin
        st = '{default: '0};
      end else begin
        n = 26'(h - 2) * 26'(w - 2);
        st.var_q8 = variance_of(n);
        st.lap_sum = acc_sum;
        st.lap_sq = acc_sq;
        st.count = n[CNT_W-1:0];
      end
      pending_stats.push_back(st);
      acc_sum = '0;
      acc_sq = '0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", what);
    endfunction

    // Compares one result word against the oldest expected statistics.
    function void check_result(focus_stats_t got);
      focus_stats_t exp_st;
      if (pending_stats.size() == 0) begin
        report("result word arrived with nothing expected");
        return;
      end
      exp_st = pending_stats.pop_front();
      frames_checked++;
      if (got.var_q8 !== exp_st.var_q8)
        report($sformatf("variance_q8 exp %0d got %0d", exp_st.var_q8, got.var_q8));
      if (got.lap_sum !== exp_st.lap_sum)
        report($sformatf("laplacian_sum exp %0d got %0d", exp_st.lap_sum, got.lap_sum));
      if (got.lap_sq !== exp_st.lap_sq)
        report($sformatf("laplacian_sum_squares exp %0d got %0d", exp_st.lap_sq, got.lap_sq));
      if (got.count !== exp_st.count)
        report($sformatf("interior_count exp %0d got %0d", exp_st.count, got.count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  lvf_pix_if pix_if ();
  lvf_cfg_if cfg_if ();
  lvf_res_if res_if ();

  laplacian_variance_focus_unit dut (
    .clk(clk),
    .rst(rst),
    .pixels(pix_if),
    .cfg(cfg_if),
    .results(res_if)
  );

  focus_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int pixels_sent = 0;
  int stall_count = 0;

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    focus_stats_t got;
    int hold_left, burst;
    hold_left = 0;
    burst = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got.var_q8 = res_if.variance_q8;
        got.lap_sum = res_if.laplacian_sum;
        got.lap_sq = res_if.laplacian_sum_squares;
        got.count = res_if.interior_count;
        sb.check_result(got);
      end
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Watchdog expired with no progress");
      $display("simulation failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic sof);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    pix_if.start_of_frame <= sof;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    sb.note_pixel(px, sof);
    pixels_sent++;
  endtask

  // Waits until every expected word is in and the pipeline has drained.
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (sb.pending_stats.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One whole frame; style 0 random, 1 black/white, 2 flat, 3 checkerboard.
  task automatic send_frame(int pix_count, int w, int style);
    logic [PIX_W-1:0] flat, px;
    logic sof;
    flat = PIX_W'($urandom_range(0, 255));
    for (int i = 0; i < pix_count; i++) begin
      case (style)
        0: px = PIX_W'($urandom_range(0, 255));
        1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2: px = flat;
        default: px = (((i % w) + (i / w)) % 2) ? 8'hFF : 8'h00;
      endcase
      sof = (i == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
      send_pixel(px, sof);
    end
  endtask

  task automatic run_phase(logic [DIM_W-1:0] w_reg, logic [DIM_W-1:0] h_reg, int frames);
    int w, h, prefix;
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w_reg);
    write_reg(REG_FRAME_HEIGHT, h_reg);
    w = sb.clamp(w_reg, MAXW);
    h = sb.clamp(h_reg, MAXH);
    for (int f = 0; f < frames; f++) begin
      // Now and then a broken frame: a stray prefix cut short by a frame start.
      if ($urandom_range(0, 15) == 0) begin
        prefix = $urandom_range(1, w * h);
        for (int i = 0; i < prefix - 1; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
        send_pixel(PIX_W'($urandom_range(0, 255)), 1'b1);
        for (int i = 1; i < w * h; i++) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_frame(w * h, w, $urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    int phase;
    logic [DIM_W-1:0] w_reg, h_reg;
    sb.clear_state();
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    pix_if.start_of_frame <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_FRAME_WIDTH;
    cfg_if.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: largest negative Laplacian, from a checkerboard and a dark centre, then degenerate sizes.
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    send_frame(9, 3, 3);
    send_pixel(8'h00, 1'b1);
    for (int i = 1; i < 9; i++) send_pixel(i == 4 ? 8'h00 : 8'hFF, 1'b0);
    run_phase(13'd0, 13'd0, 2);
    run_phase(13'd1, 13'd4, 1);
    run_phase(13'd2, 13'd2, 1);

    // Random phases, with a tall narrow and a wide short frame mixed in.
    phase = 0;
    while (pixels_sent < 1300) begin
      if (pixels_sent > 1100) quiet = 1'b1;
      w_reg = DIM_W'($urandom_range(3, 12));
      h_reg = DIM_W'($urandom_range(3, 10));
      if ($urandom_range(0, 7) == 0) w_reg = DIM_W'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) h_reg = DIM_W'($urandom_range(0, 2));
      case (phase)
        2: begin w_reg = 13'd3; h_reg = 13'd40; end
        4: begin w_reg = 13'd40; h_reg = 13'd3; end
        default: ;
      endcase
      if (phase == 3) begin
        // Result side holds off while tiny frames keep coming, filling the queue.
        wait_idle();
        hold_req = 1'b1;
        run_phase(13'd3, 13'd3, 20);
      end else begin
        run_phase(w_reg, h_reg, (phase == 2 || phase == 4) ? 1 : $urandom_range(1, 4));
      end
      phase++;
    end

    wait_idle();
    $display("Covered %0d pixel words and %0d frame results over %0d register settings.",
             pixels_sent, sb.frames_checked, phase + 4);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/lvf_pkg.sv
sv/lvf_if.sv
sv/lvf_front.sv
sv/lvf_fifo.sv
sv/lvf_back.sv
sv/laplacian_variance_focus_unit.sv
test/laplacian_variance_focus_unit_tb.sv
